[rtl/core/bap_pkg.sv]
// Shared types, constants and helpers for the button address programmer.
// No dependencies; imported by every module of the block.
`default_nettype none

package bap_pkg;

    // field and register widths
    localparam int ADDR_W = 4;
    localparam int TIMER_W = 16;
    localparam int DEBOUNCE_W = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int PHASE_W = 3;

    // click count saturation: the address maximum, held to what four bits carry
    localparam int ADDRESS_MAX = 15;
    localparam int CLICK_SAT = (ADDRESS_MAX < 15) ? ADDRESS_MAX : 15;
    localparam logic [ADDR_W-1:0] CLICK_SAT_C = ADDR_W'(CLICK_SAT);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLINK_HALF = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FLASH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LED_IDLE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_START_ADDR = 3'd5;

    // configuration reset values
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 8'd20;
    localparam logic [TIMER_W-1:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [TIMER_W-1:0] BLINK_HALF_RST = 16'd250;
    localparam logic [TIMER_W-1:0] FLASH_RST = 16'd100;
    localparam logic LED_IDLE_RST = 1'b0;
    localparam logic [ADDR_W-1:0] START_ADDR_RST = 4'd0;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_LOOP = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DEBOUNCE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HOLD = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd3;
    localparam logic [PHASE_W-1:0] PH_FLASH = 3'd4;
    localparam logic [PHASE_W-1:0] PH_BLINK_ON = 3'd5;
    localparam logic [PHASE_W-1:0] PH_BLINK_OFF = 3'd6;
    localparam logic [PHASE_W-1:0] PH_DONE = 3'd7;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_ticks;
        logic [TIMER_W-1:0] long_press_ticks;
        logic [TIMER_W-1:0] blink_half_ticks;
        logic [TIMER_W-1:0] flash_ticks;
        logic led_idle_level;
        logic start_load;
        logic [ADDR_W-1:0] start_address;
    } bap_cfg_t;

    typedef struct packed {
        logic led_level;
        logic write_strobe;
        logic [ADDR_W-1:0] write_address;
        logic address_mode;
        logic session_done;
    } bap_result_t;

    // a zero time setting counts as one tick
    function automatic logic [TIMER_W-1:0] at_least_one(input logic [TIMER_W-1:0] v);
        logic [TIMER_W-1:0] r;
        r = (v == '0) ? TIMER_W'(1) : v;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/bap_cfg.sv]
// Configuration register file of the button address programmer.
// Depends on bap_pkg for widths, register indexes and reset values.
`default_nettype none

module bap_cfg
    import bap_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output bap_cfg_t                    cfg
);

    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [TIMER_W-1:0] long_press_reg;
    logic [TIMER_W-1:0] blink_half_reg;
    logic [TIMER_W-1:0] flash_reg;
    logic led_idle_reg;

    // register writes, unknown indexes ignored; the start address is loaded in the core
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            long_press_reg <= LONG_PRESS_RST;
            blink_half_reg <= BLINK_HALF_RST;
            flash_reg <= FLASH_RST;
            led_idle_reg <= LED_IDLE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE:   debounce_reg <= cfg_data[DEBOUNCE_W-1:0];
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                REG_BLINK_HALF: blink_half_reg <= cfg_data;
                REG_FLASH:      flash_reg <= cfg_data;
                REG_LED_IDLE:   led_idle_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // start address goes straight to the core with a load pulse
    always_comb
    begin
        cfg.debounce_ticks = debounce_reg;
        cfg.long_press_ticks = long_press_reg;
        cfg.blink_half_ticks = blink_half_reg;
        cfg.flash_ticks = flash_reg;
        cfg.led_idle_level = led_idle_reg;
        cfg.start_load = cfg_we && (cfg_index == REG_START_ADDR);
        cfg.start_address = cfg_data[ADDR_W-1:0];
    end

endmodule

`default_nettype wire

[rtl/core/bap_core.sv]
// Per-tick state update of the button address programmer: debounce, hold
// timing, mode toggle, flash and blink sequencing. Depends on bap_pkg.
`default_nettype none

module bap_core
    import bap_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  step,
    input  wire logic  button_level,
    input  wire bap_cfg_t cfg,
    output bap_result_t result
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic mode_reg, mode_next;
    logic led_state_reg, led_state_next;
    logic led_drive_reg, led_drive_next;
    logic prev_level_reg, prev_level_next;
    logic [ADDR_W-1:0] click_reg, click_next;
    logic [ADDR_W-1:0] stored_reg, stored_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [ADDR_W-1:0] blinks_reg, blinks_next;
    logic done_reg, done_next;
    logic committed_reg, committed_next;
    logic strobe;
    logic [TIMER_W-1:0] timer_dec;
    logic [ADDR_W-1:0] blinks_dec;

    assign timer_dec = timer_reg - TIMER_W'(1);
    assign blinks_dec = blinks_reg - ADDR_W'(1);

    // next state for one tick
    always_comb
    begin
        phase_next = phase_reg;
        mode_next = mode_reg;
        led_state_next = led_state_reg;
        led_drive_next = led_drive_reg;
        prev_level_next = prev_level_reg;
        click_next = click_reg;
        stored_next = stored_reg;
        timer_next = timer_reg;
        blinks_next = blinks_reg;
        done_next = done_reg;
        committed_next = committed_reg;
        strobe = 1'b0;

        case (phase_reg)
            PH_LOOP:
            begin
                led_drive_next = led_state_reg;
                if (button_level != prev_level_reg)
                begin
                    prev_level_next = button_level;
                    if (cfg.debounce_ticks == '0)
                    begin
                        // resample at once
                        if (button_level)
                        begin
                            if (click_reg < CLICK_SAT_C)
                                click_next = click_reg + ADDR_W'(1);
                            timer_next = '0;
                            phase_next = PH_HOLD;
                        end
                        else if (!mode_reg)
                        begin
                            done_next = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                            phase_next = PH_LOOP;
                    end
                    else
                    begin
                        timer_next = TIMER_W'(cfg.debounce_ticks);
                        phase_next = PH_DEBOUNCE;
                    end
                end
                else if (!button_level && !mode_reg)
                begin
                    done_next = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_DEBOUNCE:
            begin
                timer_next = timer_dec;
                if (timer_dec == '0)
                begin
                    if (button_level)
                    begin
                        if (click_reg < CLICK_SAT_C)
                            click_next = click_reg + ADDR_W'(1);
                        timer_next = '0;
                        phase_next = PH_HOLD;
                    end
                    else if (!mode_reg)
                    begin
                        done_next = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                        phase_next = PH_LOOP;
                end
            end
            PH_HOLD:
            begin
                if (timer_reg < cfg.long_press_ticks)
                begin
                    timer_next = timer_reg + TIMER_W'(1);
                    if (!button_level)
                    begin
                        // short click
                        if (mode_reg)
                        begin
                            led_drive_next = ~led_state_reg;
                            timer_next = at_least_one(cfg.flash_ticks);
                            phase_next = PH_FLASH;
                        end
                        else if (stored_reg == '0)
                        begin
                            done_next = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            blinks_next = stored_reg;
                            timer_next = at_least_one(cfg.blink_half_ticks);
                            phase_next = PH_BLINK_ON;
                        end
                    end
                end
                else
                begin
                    // long press toggles the mode
                    if (mode_reg)
                    begin
                        stored_next = click_reg - ADDR_W'(1);
                        strobe = 1'b1;
                        committed_next = 1'b1;
                    end
                    else
                        click_next = '0;
                    mode_next = ~mode_reg;
                    led_state_next = ~led_state_reg;
                    led_drive_next = ~led_state_reg;
                    if (button_level)
                        phase_next = PH_RELEASE;
                    else if (mode_reg)
                    begin
                        done_next = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                        phase_next = PH_LOOP;
                end
            end
            PH_RELEASE:
            begin
                if (!button_level)
                begin
                    if (!mode_reg)
                    begin
                        done_next = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                        phase_next = PH_LOOP;
                end
            end
            PH_FLASH:
            begin
                timer_next = timer_dec;
                if (timer_dec == '0)
                begin
                    led_drive_next = led_state_reg;
                    phase_next = PH_LOOP;
                end
            end
            PH_BLINK_ON:
            begin
                timer_next = timer_dec;
                if (timer_dec == '0)
                begin
                    led_drive_next = 1'b1;
                    if (button_level)
                    begin
                        done_next = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        timer_next = at_least_one(cfg.blink_half_ticks);
                        phase_next = PH_BLINK_OFF;
                    end
                end
            end
            PH_BLINK_OFF:
            begin
                timer_next = timer_dec;
                if (timer_dec == '0)
                begin
                    led_drive_next = 1'b0;
                    if (button_level)
                    begin
                        done_next = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        blinks_next = blinks_dec;
                        if (blinks_dec == '0)
                        begin
                            done_next = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            timer_next = at_least_one(cfg.blink_half_ticks);
                            phase_next = PH_BLINK_ON;
                        end
                    end
                end
            end
            default:
                phase_next = PH_DONE;
        endcase
    end

    // result of this tick
    always_comb
    begin
        result.led_level = led_drive_next ^ cfg.led_idle_level;
        result.write_strobe = strobe;
        result.write_address = stored_next;
        result.address_mode = mode_next;
        result.session_done = done_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LOOP;
            mode_reg <= 1'b0;
            led_state_reg <= 1'b0;
            led_drive_reg <= 1'b0;
            prev_level_reg <= 1'b0;
            click_reg <= '0;
            stored_reg <= START_ADDR_RST;
            timer_reg <= '0;
            blinks_reg <= '0;
            done_reg <= 1'b0;
            committed_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            mode_reg <= mode_next;
            led_state_reg <= led_state_next;
            led_drive_reg <= led_drive_next;
            prev_level_reg <= prev_level_next;
            click_reg <= click_next;
            stored_reg <= stored_next;
            timer_reg <= timer_next;
            blinks_reg <= blinks_next;
            done_reg <= done_next;
            committed_reg <= committed_next;
        end
        else if (cfg.start_load && !committed_reg)
        begin
            // start address only counts until the first commit
            stored_reg <= cfg.start_address;
        end
    end

    // a commit only happens when leaving address mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && strobe) |-> (mode_reg && !mode_next))
        else $error("commit strobe outside address mode exit");

    // a finished session stays finished
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("session done flag dropped");

    // the done flag and the done phase go together
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (phase_reg == PH_DONE))
        else $error("done flag without done phase");

    // click count never passes its saturation point
    assert property (@(posedge clk) disable iff (!rst_n)
        click_reg <= CLICK_SAT_C)
        else $error("click count above saturation");

endmodule

`default_nettype wire

[rtl/core/bap_obuf.sv]
// Two-entry output buffer of the button address programmer: a result
// register plus a skid entry. Depends on bap_pkg for the result type.
`default_nettype none

module bap_obuf
    import bap_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire bap_result_t push_data,
    output logic       push_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    output bap_result_t out_data
);

    logic main_valid_reg;
    logic skid_valid_reg;
    bap_result_t main_reg;
    bap_result_t skid_reg;
    logic pop;

    assign pop = main_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data = main_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
        else if (pop)
            main_valid_reg <= 1'b0;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
                skid_reg <= push_data;
            else
                main_reg <= push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/button_address_programmer.sv]
// Button address programmer: one request per millisecond tick carries the
// raw button level; one result request comes back for every tick.
// Input channel: in_valid / in_ready with button_level.
// Output channel: out_valid / out_ready with led_level, write_strobe,
// write_address, address_mode and session_done.
// Configuration: cfg_we with cfg_index and cfg_data, taken on the clock edge,
// index 0 debounce, 1 long press, 2 blink half period, 3 flash time,
// 4 LED idle level, 5 start address; write only while the block is idle.
// Result path: the state update between the state and result registers is
// combinational; a tick's result is registered when its request is taken.
// Throughput: one tick per cycle while in_ready is high.
// Stall: a two-entry output buffer keeps in_ready high while one result
// waits; with two results held, in_ready drops until out_ready takes one.
// Reset: configuration returns to its defaults, the sequencer waits for the
// button in idle mode, the stored address is the start address, and the
// output buffer is empty.
// Depends on bap_pkg, bap_cfg, bap_core and bap_obuf.
`default_nettype none

module button_address_programmer
    import bap_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   button_level,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        led_level,
    output logic                        write_strobe,
    output logic [ADDR_W-1:0]           write_address,
    output logic                        address_mode,
    output logic                        session_done
);

    bap_cfg_t cfg;
    bap_result_t step_result;
    bap_result_t out_data;
    logic step;

    assign step = in_valid && in_ready;

    // configuration registers
    bap_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // tick sequencer
    bap_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .button_level (button_level),
        .cfg          (cfg),
        .result       (step_result)
    );

    // result register with skid entry
    bap_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step),
        .push_data  (step_result),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // output fields
    assign led_level = out_data.led_level;
    assign write_strobe = out_data.write_strobe;
    assign write_address = out_data.write_address;
    assign address_mode = out_data.address_mode;
    assign session_done = out_data.session_done;

endmodule

`default_nettype wire
